// File: hw/rtl/stbt_pkg.sv
// ----------------------------------------------------------------------------
// stbt_pkg
// Shared types and constants for the timer bank: channel record, item
// kinds and the command/status groups between controller and datapath.
// ----------------------------------------------------------------------------
package stbt_pkg;

   localparam logic [31:0] COUNT_MAX = 32'hFFFF_FFFF;

   // item kinds; any other code is handled like a read
   localparam logic [1:0] KIND_TICK  = 2'd0;
   localparam logic [1:0] KIND_WRITE = 2'd1;
   localparam logic [1:0] KIND_READ  = 2'd2;

   // one channel as stored in the bank RAM
   typedef struct packed {
      logic        error;
      logic        down;
      logic        up;
      logic        enable;
      logic [31:0] count;
   } chan_type;

   // controller -> datapath
   typedef struct packed {
      logic load_item;  // latch request, clear walk index
      logic rd_tick;    // read channel at walk index
      logic wr_tick;    // write back ticked channel, advance index
      logic wr_chan;    // load addressed channel from request
      logic rd_chan;    // read addressed channel
      logic cap_rsp;    // move read data into output register
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic is_tick;
      logic is_write;
      logic walk_empty;
      logic walk_last;
      logic out_free;
   } status_type;

endpackage

// File: hw/rtl/stbt_ram.sv
// ----------------------------------------------------------------------------
// stbt_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module stbt_ram #(
   parameter int WIDTH = 36,
   parameter int DEPTH = 8
) (
   input  logic                                   clock,
   input  logic                                   wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                       wr_data,
   input  logic                                   rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                       rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: hw/rtl/stbt_ctrl.sv
// ----------------------------------------------------------------------------
// stbt_ctrl
// Sequencer: takes one transaction, walks the bank on a tick, loads on a
// write, then reads the addressed channel into the output register.
// ----------------------------------------------------------------------------
module stbt_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   input  stbt_pkg::status_type sts_i,
   output stbt_pkg::cmd_type    cmd_o
);
   import stbt_pkg::*;

   typedef enum logic [6:0] {
      S_IDLE     = 7'b0000001,
      S_DISPATCH = 7'b0000010,
      S_TICK_RD  = 7'b0000100,
      S_TICK_WR  = 7'b0001000,
      S_CHAN_WR  = 7'b0010000,
      S_RSP_RD   = 7'b0100000,
      S_RSP_CAP  = 7'b1000000
   } state_type;

   state_type state_ff;
   state_type state_in;

   always_comb begin
      state_in = state_ff;
      cmd_o    = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               cmd_o.load_item = 1'b1;
               state_in        = S_DISPATCH;
            end
         end
         S_DISPATCH: begin
            priority if (sts_i.is_tick && !sts_i.walk_empty) begin
               state_in = S_TICK_RD;
            end else if (sts_i.is_write) begin
               state_in = S_CHAN_WR;
            end else begin
               state_in = S_RSP_RD;
            end
         end
         S_TICK_RD: begin
            cmd_o.rd_tick = 1'b1;
            state_in      = S_TICK_WR;
         end
         S_TICK_WR: begin
            cmd_o.wr_tick = 1'b1;
            state_in      = sts_i.walk_last ? S_RSP_RD : S_TICK_RD;
         end
         S_CHAN_WR: begin
            cmd_o.wr_chan = 1'b1;
            state_in      = S_RSP_RD;
         end
         S_RSP_RD: begin
            cmd_o.rd_chan = 1'b1;
            state_in      = S_RSP_CAP;
         end
         S_RSP_CAP: begin
            if (sts_i.out_free) begin
               cmd_o.cap_rsp = 1'b1;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // no transaction is taken while reset is held
   assign req_tready = (state_ff == S_IDLE) && !reset;

   // a write-back is always preceded by its read
   a_tick_wr_after_rd: assert property (@(posedge clock) disable iff (reset)
      cmd_o.wr_tick |-> $past(cmd_o.rd_tick))
      else $error("tick write-back without preceding read");

endmodule

// File: hw/rtl/stbt_dp.sv
// ----------------------------------------------------------------------------
// stbt_dp
// Datapath: channel RAM with valid and error mirrors, walk index, shared
// tick update unit and the result register.
// ----------------------------------------------------------------------------
module stbt_dp #(
   parameter int NUM_CHANNELS = 8,
   parameter int STEP         = 1
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_wr_en,
   input  logic [3:0]           csr_wr_data,
   input  logic [1:0]           req_kind,
   input  logic [2:0]           req_channel,
   input  stbt_pkg::chan_type   req_chan,
   input  stbt_pkg::cmd_type    cmd_i,
   output stbt_pkg::status_type sts_o,
   input  logic                 rsp_tready,
   output logic                 rsp_tvalid,
   output stbt_pkg::chan_type   rsp_chan,
   output logic [7:0]           rsp_mask
);
   import stbt_pkg::*;

   localparam int          CH_W     = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
   localparam int          MASK_N   = (NUM_CHANNELS < 8) ? NUM_CHANNELS : 8;
   localparam logic [31:0] STEP_W   = 32'(STEP);
   localparam logic [31:0] UP_LIMIT = COUNT_MAX - STEP_W;

   logic [3:0]              active_ff, active_in;
   logic [1:0]              kind_ff, kind_in;
   logic [2:0]              chan_ff, chan_in;
   chan_type                wdata_ff, wdata_in;
   logic [CH_W-1:0]         idx_ff, idx_in;
   logic [NUM_CHANNELS-1:0] valid_ff, valid_in;
   logic [NUM_CHANNELS-1:0] err_ff, err_in;
   logic                    rd_ok_ff, rd_ok_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   chan_type                rsp_chan_ff, rsp_chan_in;
   logic [7:0]              rsp_mask_ff, rsp_mask_in;

   logic [3:0]              n_eff;
   logic                    chan_ok;
   logic [CH_W-1:0]         chan_addr;
   chan_type                cur;
   chan_type                nxt;
   logic                    ram_we;
   logic [CH_W-1:0]         ram_waddr;
   chan_type                ram_wdata;
   logic                    ram_re;
   logic [CH_W-1:0]         ram_raddr;
   logic [$bits(chan_type)-1:0] ram_q;
   logic                    out_free;

   stbt_ram #(
      .WIDTH ($bits(chan_type)),
      .DEPTH (NUM_CHANNELS)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_en   (ram_re),
      .rd_addr (ram_raddr),
      .rd_data (ram_q)
   );

   always_comb begin
      n_eff     = (32'(active_ff) > NUM_CHANNELS) ? 4'(NUM_CHANNELS) : active_ff;
      chan_ok   = (32'(chan_ff) < NUM_CHANNELS);
      chan_addr = CH_W'(chan_ff);
      // never-written entries read as the reset value
      cur       = rd_ok_ff ? chan_type'(ram_q) : '0;
      out_free  = !rsp_valid_ff || rsp_tready;
   end

   // shared tick update; up has priority over down
   always_comb begin
      nxt = cur;
      if (cur.enable) begin
         if (cur.up) begin
            if (cur.count == COUNT_MAX) begin
               nxt.error = 1'b1;
            end else begin
               nxt.count = (cur.count > UP_LIMIT) ? COUNT_MAX : cur.count + STEP_W;
            end
         end else if (cur.down) begin
            priority if (cur.count == '0) begin
               nxt.enable = 1'b0;
               nxt.error  = 1'b1;
            end else if (cur.count >= STEP_W) begin
               nxt.count = cur.count - STEP_W;
            end else begin
               nxt.count = '0;
               nxt.error = 1'b1;
            end
         end
      end
   end

   always_comb begin
      ram_we    = cmd_i.wr_tick || (cmd_i.wr_chan && chan_ok);
      ram_waddr = cmd_i.wr_tick ? idx_ff : chan_addr;
      ram_wdata = cmd_i.wr_tick ? nxt : wdata_ff;
      ram_re    = cmd_i.rd_tick || cmd_i.rd_chan;
      ram_raddr = cmd_i.rd_tick ? idx_ff : chan_addr;
   end

   always_comb begin
      active_in    = csr_wr_en ? csr_wr_data : active_ff;
      kind_in      = cmd_i.load_item ? req_kind : kind_ff;
      chan_in      = cmd_i.load_item ? req_channel : chan_ff;
      wdata_in     = cmd_i.load_item ? req_chan : wdata_ff;

      idx_in = idx_ff;
      if (cmd_i.load_item) begin
         idx_in = '0;
      end else if (cmd_i.wr_tick) begin
         idx_in = idx_ff + 1'b1;
      end

      valid_in = valid_ff;
      err_in   = err_ff;
      if (ram_we) begin
         valid_in[ram_waddr] = 1'b1;
         err_in[ram_waddr]   = ram_wdata.error;
      end

      rd_ok_in = ram_re ? valid_ff[ram_raddr] : rd_ok_ff;

      rsp_chan_in  = rsp_chan_ff;
      rsp_mask_in  = rsp_mask_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      if (cmd_i.cap_rsp) begin
         rsp_chan_in  = chan_ok ? cur : '0;
         rsp_mask_in  = 8'(err_ff[MASK_N-1:0]);
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff    <= '0;
         idx_ff       <= '0;
         valid_ff     <= '0;
         err_ff       <= '0;
         rd_ok_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         active_ff    <= active_in;
         idx_ff       <= idx_in;
         valid_ff     <= valid_in;
         err_ff       <= err_in;
         rd_ok_ff     <= rd_ok_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff     <= kind_in;
      chan_ff     <= chan_in;
      wdata_ff    <= wdata_in;
      rsp_chan_ff <= rsp_chan_in;
      rsp_mask_ff <= rsp_mask_in;
   end

   always_comb begin
      sts_o.is_tick    = (kind_ff == KIND_TICK);
      sts_o.is_write   = (kind_ff == KIND_WRITE);
      sts_o.walk_empty = (n_eff == '0);
      sts_o.walk_last  = ((32'(idx_ff) + 32'd1) == 32'(n_eff));
      sts_o.out_free   = out_free;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_chan   = rsp_chan_ff;
   assign rsp_mask   = rsp_mask_ff;

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd_i.cap_rsp |-> out_free)
      else $error("result register overwritten while waiting");

   a_walk_in_range: assert property (@(posedge clock) disable iff (reset)
      cmd_i.wr_tick |-> (32'(idx_ff) < 32'(n_eff)))
      else $error("tick walk beyond active channels");

   a_mask_tracks_write: assert property (@(posedge clock) disable iff (reset)
      (cmd_i.wr_chan && chan_ok) |=> (err_ff[$past(chan_addr)] == $past(wdata_ff.error)))
      else $error("error mirror out of step with channel write");

endmodule

// File: hw/rtl/software_timer_bank_tick.sv
// ----------------------------------------------------------------------------
// software_timer_bank_tick
// Bank of up/down timer channels driven by tick, write and read
// transactions; one result per transaction.
// ----------------------------------------------------------------------------
// Usage:
//   req_*  : input transactions. tuser carries the kind (tick, write, read;
//            the unused code acts as a read), tdata the channel address and
//            the values a write loads.
//   rsp_*  : one result per request: the addressed channel after the step
//            and the error flags of channels 0..7.
//   csr_*  : active channel count, to be written only while the bank is idle;
//            the user must keep to this, the block itself does not enforce it.
// Timing: one transaction at a time. A tick walks N channels, where N is the
//   active channel count (clipped to NUM_CHANNELS). The result appears in
//   the cycle the bank is ready again. Each ticked channel takes a RAM read
//   step and an update/write-back step through the single shared
//   add/subtract unit.
// Stall: the result waits in its output register; the next request is
//   still accepted and worked, and only its own result capture waits.
// Reset: synchronous; clears all channels (through per-entry valid bits,
//   no clearing pass) and the active count. Ready the cycle after reset.
// ----------------------------------------------------------------------------
module software_timer_bank_tick #(
   parameter int NUM_CHANNELS = 8,
   parameter int STEP         = 1
) (
   input  logic        clock,
   input  logic        reset,
   // configuration
   input  logic        csr_wr_en,
   input  logic [3:0]  csr_wr_data,   // active_channels
   // request channel
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [1:0]  req_tuser,     // [1:0] kind
   input  logic [39:0] req_tdata,     // [2:0] channel, [34:3] new_count,
                                      // [35] new_enable, [36] new_up,
                                      // [37] new_down, [38] new_error, [39] 0
   // result channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata      // [31:0] count_out, [32] enable_out,
                                      // [33] up_out, [34] down_out,
                                      // [35] error_out, [43:36] error_mask,
                                      // [47:44] 0
);
   import stbt_pkg::*;

   cmd_type    cmd;
   status_type sts;
   chan_type   req_chan;
   chan_type   rsp_chan;
   logic [7:0] rsp_mask;

   // unpack request payload into a channel record
   always_comb begin
      req_chan.count  = req_tdata[34:3];
      req_chan.enable = req_tdata[35];
      req_chan.up     = req_tdata[36];
      req_chan.down   = req_tdata[37];
      req_chan.error  = req_tdata[38];
   end

   stbt_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .sts_i      (sts),
      .cmd_o      (cmd)
   );

   stbt_dp #(
      .NUM_CHANNELS (NUM_CHANNELS),
      .STEP         (STEP)
   ) u_dp (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_kind    (req_tuser),
      .req_channel (req_tdata[2:0]),
      .req_chan    (req_chan),
      .cmd_i       (cmd),
      .sts_o       (sts),
      .rsp_tready  (rsp_tready),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_chan    (rsp_chan),
      .rsp_mask    (rsp_mask)
   );

   // pack result: count first, then the flag bits, then the mask
   assign rsp_tdata = {4'b0000, rsp_mask, rsp_chan.error, rsp_chan.down,
                       rsp_chan.up, rsp_chan.enable, rsp_chan.count};

endmodule

// File: test/software_timer_bank_tick_test.sv
// ----------------------------------------------------------------------------
// software_timer_bank_tick_test
// Self-checking bench for the timer bank. A directed table walks the reset
// state, saturation, expiry, mode priority, disabled and idle channels, the
// spare kind and the active-count extremes; random tick/write/read traffic
// follows in phases with different active counts and handshake idling.
// Every result transaction is checked against a local model of the bank or a typed row.
// ----------------------------------------------------------------------------
module software_timer_bank_tick_test;
   timeunit 1ns;
   timeprecision 1ps;

   import stbt_pkg::*;

   localparam int NUM_CHANNELS  = 8;
   localparam int STEP          = 1;
   localparam int SETTLE_CYCLES = 8;        // idle wait before a csr write
   localparam int TAIL_CYCLES   = 40;       // quiet time after the last result
   localparam int HOLD_CYCLES   = 300;      // long receiver hold-off
   localparam int CYCLE_LIMIT   = 200_000;  // watchdog

   // spare kind code; the bank treats it as a read
   localparam logic [1:0] KIND_SPARE = 2'd3;

   // one request transaction
   typedef struct packed {
      logic [1:0]  kind;
      logic [2:0]  channel;
      logic [31:0] count;
      logic        enable;
      logic        up;
      logic        down;
      logic        error;
   } timer_item_type;

   // one result transaction
   typedef struct packed {
      logic [31:0] count;
      logic        enable;
      logic        up;
      logic        down;
      logic        error;
      logic [7:0]  mask;
   } timer_status_type;

   // directed row: optional csr write first, then the item; typed result
   // only where it is obvious, otherwise the model decides
   typedef struct packed {
      logic             cfg_wr;
      logic [3:0]       cfg_val;
      timer_item_type   item;
      logic             typed;
      timer_status_type status;
   } directed_row_type;

   localparam timer_status_type NO_STATUS = '0;
   localparam logic [31:0]      CMAX      = COUNT_MAX;

   localparam int N_DIRECTED = 25;
   localparam directed_row_type DIRECTED_ROWS [N_DIRECTED] = '{
      // fresh bank: read and a tick with no active channels return zeros
      '{1'b0, 4'd0, '{KIND_READ,  3'd0, 32'd0, 1'b0, 1'b0, 1'b0, 1'b0}, 1'b1, NO_STATUS},
      '{1'b0, 4'd0, '{KIND_TICK,  3'd5, 32'd0, 1'b0, 1'b0, 1'b0, 1'b0}, 1'b1, NO_STATUS},
      // up channel parked at max, down channel parked at zero
      '{1'b0, 4'd0, '{KIND_WRITE, 3'd0, CMAX,  1'b1, 1'b1, 1'b0, 1'b0}, 1'b1,
        '{CMAX,  1'b1, 1'b1, 1'b0, 1'b0, 8'd0}},
      '{1'b0, 4'd0, '{KIND_WRITE, 3'd1, 32'd0, 1'b1, 1'b0, 1'b1, 1'b0}, 1'b1,
        '{32'd0, 1'b1, 1'b0, 1'b1, 1'b0, 8'd0}},
      // active count 0: tick is a no-op
      '{1'b0, 4'd0, '{KIND_TICK,  3'd0, 32'd0, 1'b0, 1'b0, 1'b0, 1'b0}, 1'b0, NO_STATUS},
      // all eight active: saturation error on ch0, expiry on ch1
      '{1'b1, 4'd8, '{KIND_TICK,  3'd0, 32'd0, 1'b0, 1'b0, 1'b0, 1'b0}, 1'b0, NO_STATUS},
      '{1'b0, 4'd0, '{KIND_READ,  3'd1, 32'd0, 1'b0, 1'b0, 1'b0, 1'b0}, 1'b0, NO_STATUS},
      // count down 1 -> 0 -> expired
      '{1'b0, 4'd0, '{KIND_WRITE, 3'd2, 32'd1, 1'b1, 1'b0, 1'b1, 1'b0}, 1'b0, NO_STATUS},
      '{1'b0, 4'd0, '{KIND_TICK,  3'd2, 32'd0, 1'b0, 1'b0, 1'b0, 1'b0}, 1'b0, NO_STATUS},
      '{1'b0, 4'd0, '{KIND_TICK,  3'd2, 32'd0, 1'b0, 1'b0, 1'b0, 1'b0}, 1'b0, NO_STATUS},
      // up and down both set: up wins, reaches max, then flags
      '{1'b0, 4'd0, '{KIND_WRITE, 3'd3, CMAX - 32'd1, 1'b1, 1'b1, 1'b1, 1'b0}, 1'b0,
        NO_STATUS},
      '{1'b0, 4'd0, '{KIND_TICK,  3'd3, 32'd0, 1'b0, 1'b0, 1'b0, 1'b0}, 1'b0, NO_STATUS},
      '{1'b0, 4'd0, '{KIND_TICK,  3'd3, 32'd0, 1'b0, 1'b0, 1'b0, 1'b0}, 1'b0, NO_STATUS},
      // disabled channel and enabled channel with no mode stay put
      '{1'b0, 4'd0, '{KIND_WRITE, 3'd4, 32'd5, 1'b0, 1'b0, 1'b1, 1'b0}, 1'b0, NO_STATUS},
      '{1'b0, 4'd0, '{KIND_WRITE, 3'd5, 32'd7, 1'b1, 1'b0, 1'b0, 1'b0}, 1'b0, NO_STATUS},
      '{1'b0, 4'd0, '{KIND_TICK,  3'd4, 32'd0, 1'b0, 1'b0, 1'b0, 1'b0}, 1'b0, NO_STATUS},
      '{1'b0, 4'd0, '{KIND_READ,  3'd5, 32'd0, 1'b0, 1'b0, 1'b0, 1'b0}, 1'b0, NO_STATUS},
      // error flag loaded by a write, and cleared by one
      '{1'b0, 4'd0, '{KIND_WRITE, 3'd6, 32'hAAAA_AAAA, 1'b1, 1'b0, 1'b1, 1'b1}, 1'b0,
        NO_STATUS},
      '{1'b0, 4'd0, '{KIND_WRITE, 3'd0, 32'h5555_5555, 1'b1, 1'b1, 1'b0, 1'b0}, 1'b0,
        NO_STATUS},
      // spare kind carries write-like payload but must change nothing
      '{1'b0, 4'd0, '{KIND_SPARE, 3'd6, 32'hFFFF_0000, 1'b1, 1'b1, 1'b1, 1'b1}, 1'b0,
        NO_STATUS},
      '{1'b0, 4'd0, '{KIND_WRITE, 3'd7, 32'd2, 1'b1, 1'b0, 1'b1, 1'b0}, 1'b0, NO_STATUS},
      // active count above the bank size ticks everything
      '{1'b1, 4'd15, '{KIND_TICK, 3'd7, 32'd0, 1'b0, 1'b0, 1'b0, 1'b0}, 1'b0, NO_STATUS},
      '{1'b0, 4'd0, '{KIND_TICK,  3'd7, 32'd0, 1'b0, 1'b0, 1'b0, 1'b0}, 1'b0, NO_STATUS},
      // only channel 0 ticked; ch7 must hold at zero without expiring
      '{1'b1, 4'd1, '{KIND_TICK,  3'd7, 32'd0, 1'b0, 1'b0, 1'b0, 1'b0}, 1'b0, NO_STATUS},
      '{1'b0, 4'd0, '{KIND_READ,  3'd0, 32'd0, 1'b0, 1'b0, 1'b0, 1'b0}, 1'b0, NO_STATUS}
   };

   // random phases: active count, sender idle %, receiver stall %, items,
   // long hold-off on/off
   localparam int N_PHASES = 5;
   localparam int PHASE_ACTIVE   [N_PHASES] = '{8, 3, 0, 15, 5};
   localparam int PHASE_IDLE     [N_PHASES] = '{0, 47, 0, 28, 28};
   localparam int PHASE_STALL    [N_PHASES] = '{0, 0, 47, 28, 28};
   localparam int PHASE_ITEMS    [N_PHASES] = '{150, 150, 60, 170, 170};
   localparam int PHASE_PRESSURE [N_PHASES] = '{0, 0, 1, 1, 0};

   // ---------------------------------------------------------------------
   // DUT inputs, all driven to known values from time zero
   // ---------------------------------------------------------------------
   logic        clock       = 1'b0;
   logic        reset       = 1'b1;
   logic        csr_wr_en   = 1'b0;
   logic [3:0]  csr_wr_data = '0;
   logic        req_tvalid  = 1'b0;
   logic        req_tready;
   logic [1:0]  req_tuser   = '0;
   logic [39:0] req_tdata   = '0;
   logic        rsp_tvalid;
   logic        rsp_tready  = 1'b0;
   logic [47:0] rsp_tdata;

   software_timer_bank_tick #(
      .NUM_CHANNELS (NUM_CHANNELS),
      .STEP         (STEP)
   ) DUT (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tuser   (req_tuser),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata)
   );

   always #1 clock = ~clock;

   // ---------------------------------------------------------------------
   // Bank model: own copy of channel state and active count
   // ---------------------------------------------------------------------
   bit [31:0] bank_count  [NUM_CHANNELS];
   bit        bank_enable [NUM_CHANNELS];
   bit        bank_up     [NUM_CHANNELS];
   bit        bank_down   [NUM_CHANNELS];
   bit        bank_error  [NUM_CHANNELS];
   bit [3:0]  active_cfg;

   timer_status_type status_expected [$];  // results still owed by the bank

   int          mismatches    = 0;
   int          send_idle_pct = 0;
   int          rsp_stall_pct = 0;
   int          hold_requests = 0;     // bumped by the stimulus, served below
   int unsigned cycle_count   = 0;

   // apply one transaction to the bank model, return the expected result
   function automatic timer_status_type predict_item(input timer_item_type it);
      timer_status_type st;
      int               n;
      int               i;
      logic [32:0]      sum;
      n = (active_cfg > NUM_CHANNELS) ? NUM_CHANNELS : active_cfg;
      if (it.kind == KIND_TICK) begin
         for (i = 0; i < n; i++) begin
            if (!bank_enable[i]) begin
               // disabled: untouched
            end else if (bank_up[i]) begin
               if (bank_count[i] == COUNT_MAX) begin
                  bank_error[i] = 1'b1;
               end else begin
                  sum = {1'b0, bank_count[i]} + STEP;
                  bank_count[i] = (sum > {1'b0, COUNT_MAX}) ? COUNT_MAX : sum[31:0];
               end
            end else if (bank_down[i]) begin
               if (bank_count[i] == 0) begin
                  bank_enable[i] = 1'b0;
                  bank_error[i]  = 1'b1;
               end else if (bank_count[i] >= STEP) begin
                  bank_count[i] = bank_count[i] - STEP;
               end else begin
                  bank_count[i] = '0;
                  bank_error[i] = 1'b1;
               end
            end
         end
      end else if (it.kind == KIND_WRITE) begin
         bank_count[it.channel]  = it.count;
         bank_enable[it.channel] = it.enable;
         bank_up[it.channel]     = it.up;
         bank_down[it.channel]   = it.down;
         bank_error[it.channel]  = it.error;
      end
      // read and spare kinds only observe
      st.mask = '0;
      for (i = 0; i < 8; i++)
         st.mask[i] = bank_error[i];
      st.count  = bank_count[it.channel];
      st.enable = bank_enable[it.channel];
      st.up     = bank_up[it.channel];
      st.down   = bank_down[it.channel];
      st.error  = bank_error[it.channel];
      return st;
   endfunction

   // random transaction, biased toward counts near zero and near max so
   // that expiry and saturation are reached often
   function automatic timer_item_type random_item();
      timer_item_type it;
      int             r;
      r = $urandom_range(99);
      if (r < 45)      it.kind = KIND_TICK;
      else if (r < 80) it.kind = KIND_WRITE;
      else if (r < 95) it.kind = KIND_READ;
      else             it.kind = KIND_SPARE;
      it.channel = 3'($urandom_range(NUM_CHANNELS - 1));
      case ($urandom_range(7))
         0:       it.count = '0;
         1:       it.count = $urandom_range(3);
         2:       it.count = $urandom_range(20);
         3:       it.count = COUNT_MAX - $urandom_range(3);
         4:       it.count = COUNT_MAX - $urandom_range(20);
         default: it.count = $urandom();
      endcase
      it.enable = ($urandom_range(9) < 8);
      it.up     = 1'($urandom_range(1));
      it.down   = 1'($urandom_range(1));
      it.error  = ($urandom_range(3) == 0);
      return it;
   endfunction

   // ---------------------------------------------------------------------
   // Request side. Entered and left at a falling edge; tvalid stays high
   // from one transaction to the next unless an idle cycle is drawn.
   // ---------------------------------------------------------------------
   task automatic send_item(input timer_item_type it, input logic typed,
                            input timer_status_type typed_status);
      timer_status_type st;
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= it.kind;
      req_tdata  <= {1'b0, it.error, it.down, it.up, it.enable, it.count, it.channel};
      do @(posedge clock); while (!req_tready);
      // accepted at this edge: model steps now
      st = predict_item(it);
      status_expected.push_back(typed ? typed_status : st);
      @(negedge clock);
   endtask

   // csr write, only with the bank drained and quiet
   task automatic write_active(input logic [3:0] value);
      req_tvalid <= 1'b0;
      while (status_expected.size() != 0)
         @(negedge clock);
      // bank is free once the last result is out; short settle anyway
      repeat (SETTLE_CYCLES) @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(negedge clock);
      csr_wr_en  <= 1'b0;
      active_cfg = value;
   endtask

   // ---------------------------------------------------------------------
   // Result side: ready drawn per cycle at the falling edge; a hold-off
   // request blocks it for HOLD_CYCLES so the bank backs up into req_tready
   // ---------------------------------------------------------------------
   int hold_served = 0;
   int hold_left   = 0;

   always @(negedge clock) begin
      if (hold_served != hold_requests) begin
         hold_served = hold_requests;
         hold_left   = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= rsp_stall_pct);
      end
   end

   task automatic check_field(input string name, input logic [31:0] exp_val,
                              input logic [31:0] act_val);
      if (exp_val !== act_val) begin
         $error("%s: expected %0h, actual %0h", name, exp_val, act_val);
         mismatches++;
      end
   endtask

   // result transactions checked in order at the rising edge
   always @(posedge clock) begin
      timer_status_type exp_st;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (status_expected.size() == 0) begin
            $error("result transaction with nothing expected: %0h", rsp_tdata);
            mismatches++;
         end else begin
            exp_st = status_expected.pop_front();
            check_field("count_out",  exp_st.count,  rsp_tdata[31:0]);
            check_field("enable_out", 32'(exp_st.enable), 32'(rsp_tdata[32]));
            check_field("up_out",     32'(exp_st.up),     32'(rsp_tdata[33]));
            check_field("down_out",   32'(exp_st.down),   32'(rsp_tdata[34]));
            check_field("error_out",  32'(exp_st.error),  32'(rsp_tdata[35]));
            check_field("error_mask", 32'(exp_st.mask),   32'(rsp_tdata[43:36]));
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("software_timer_bank_tick_test: errors");
         $finish;
      end
   end

   // ---------------------------------------------------------------------
   // Main sequence
   // ---------------------------------------------------------------------
   initial begin
      int p;
      int n;
      int r;
      // synchronous reset held from time zero, then released once
      repeat (5) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed table, no idling on either side
      for (r = 0; r < N_DIRECTED; r++) begin
         if (DIRECTED_ROWS[r].cfg_wr)
            write_active(DIRECTED_ROWS[r].cfg_val);
         send_item(DIRECTED_ROWS[r].item, DIRECTED_ROWS[r].typed,
                   DIRECTED_ROWS[r].status);
      end

      // random phases; active count changed only between phases
      for (p = 0; p < N_PHASES; p++) begin
         write_active(4'(PHASE_ACTIVE[p]));
         send_idle_pct = PHASE_IDLE[p];
         rsp_stall_pct = PHASE_STALL[p];
         for (n = 0; n < PHASE_ITEMS[p]; n++) begin
            // sender keeps offering while the receiver is held off
            if (PHASE_PRESSURE[p] != 0 && n == PHASE_ITEMS[p] / 3)
               hold_requests++;
            send_item(random_item(), 1'b0, NO_STATUS);
         end
      end

      // drain and let the bank go quiet
      req_tvalid <= 1'b0;
      while (status_expected.size() != 0)
         @(negedge clock);
      repeat (TAIL_CYCLES) @(negedge clock);

      if (mismatches == 0)
         $display("software_timer_bank_tick_test: clean");
      else
         $display("software_timer_bank_tick_test: errors");
      $finish;
   end

endmodule
